>>> sv/midpoint_ellipse_rasterizer_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the midpoint ellipse rasterizer core
// Clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_CORE_DEFINES_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_CORE_DEFINES_SVH

// Condition that must hold at every clock edge.
`define MER_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Condition on the cycle after a trigger.
`define MER_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Condition in the same cycle as a trigger.
`define MER_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> sv/mer_pkg.sv
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer package
// Widths, microcode control word and the microcode program.
// ----------------------------------------------------------------------------
package mer_pkg;

  localparam int MAX_RADIUS = 31;
  localparam int MAX_OUT    = 2 * MAX_RADIUS + 1;

  localparam int COORD_IN_W = 12;
  localparam int COORD_W    = 14;
  localparam int RAD_W      = 5;
  localparam int SQ_W       = 2 * RAD_W;               // a2, b2
  localparam int X_W        = $clog2(MAX_OUT);         // x offset
  localparam int N_W        = $clog2(MAX_OUT + 1);     // points emitted
  localparam int MUL_W      = 2 * X_W;                 // multiplier operand
  localparam int PROD_W     = 2 * MUL_W;
  localparam int PP_W       = SQ_W + 1 + X_W;          // px, py
  localparam int P_W        = PROD_W + 2;              // decision variable
  localparam int PC_W       = 4;

  // Step addresses
  localparam logic [PC_W-1:0] PC_IDLE    = 4'd0;
  localparam logic [PC_W-1:0] PC_MUL_AA  = 4'd1;
  localparam logic [PC_W-1:0] PC_MUL_BB  = 4'd2;
  localparam logic [PC_W-1:0] PC_MUL_A2B = 4'd3;
  localparam logic [PC_W-1:0] PC_INIT    = 4'd4;
  localparam logic [PC_W-1:0] PC_R1_TEST = 4'd5;
  localparam logic [PC_W-1:0] PC_R1      = 4'd6;
  localparam logic [PC_W-1:0] PC_MUL_XX  = 4'd7;
  localparam logic [PC_W-1:0] PC_MUL_YY  = 4'd8;
  localparam logic [PC_W-1:0] PC_MUL_B2U = 4'd9;
  localparam logic [PC_W-1:0] PC_MUL_A2V = 4'd10;
  localparam logic [PC_W-1:0] PC_MUL_AB  = 4'd11;
  localparam logic [PC_W-1:0] PC_P2_SUB  = 4'd12;
  localparam logic [PC_W-1:0] PC_R2      = 4'd13;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_AA,
    MUL_BB,
    MUL_A2B,
    MUL_XX1,
    MUL_YY,
    MUL_B2U,
    MUL_A2V,
    MUL_A2B2
  } mul_sel_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SET_A2,
    OP_SET_B2,
    OP_INIT,
    OP_R1,
    OP_SET_U,
    OP_SET_V,
    OP_P2_BASE,
    OP_P2_ADD,
    OP_P2_SUB,
    OP_R2
  } op_t;

  typedef enum logic [2:0] {
    COND_NEXT,   // fall through
    COND_IN,     // hold until a request arrives
    COND_GE,     // jump when px >= py
    COND_LAST,   // back to idle on the last point, else jump
    COND_JUMP    // unconditional jump
  } cond_t;

  typedef struct packed {
    mul_sel_t        mul;
    op_t             op;
    logic            emit;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
    ctrl_word_t cw;
    cw = '{mul: MUL_NONE, op: OP_NOP, emit: 1'b0, cond: COND_JUMP, target: PC_IDLE};
    unique case (pc)
      PC_IDLE:    cw = '{MUL_NONE, OP_LOAD,    1'b0, COND_IN,   PC_IDLE};
      PC_MUL_AA:  cw = '{MUL_AA,   OP_NOP,     1'b0, COND_NEXT, PC_IDLE};
      PC_MUL_BB:  cw = '{MUL_BB,   OP_SET_A2,  1'b0, COND_NEXT, PC_IDLE};
      PC_MUL_A2B: cw = '{MUL_A2B,  OP_SET_B2,  1'b0, COND_NEXT, PC_IDLE};
      PC_INIT:    cw = '{MUL_NONE, OP_INIT,    1'b1, COND_LAST, PC_R1_TEST};
      PC_R1_TEST: cw = '{MUL_NONE, OP_NOP,     1'b0, COND_GE,   PC_MUL_XX};
      PC_R1:      cw = '{MUL_NONE, OP_R1,      1'b1, COND_LAST, PC_R1_TEST};
      PC_MUL_XX:  cw = '{MUL_XX1,  OP_NOP,     1'b0, COND_NEXT, PC_IDLE};
      PC_MUL_YY:  cw = '{MUL_YY,   OP_SET_U,   1'b0, COND_NEXT, PC_IDLE};
      PC_MUL_B2U: cw = '{MUL_B2U,  OP_SET_V,   1'b0, COND_NEXT, PC_IDLE};
      PC_MUL_A2V: cw = '{MUL_A2V,  OP_P2_BASE, 1'b0, COND_NEXT, PC_IDLE};
      PC_MUL_AB:  cw = '{MUL_A2B2, OP_P2_ADD,  1'b0, COND_NEXT, PC_IDLE};
      PC_P2_SUB:  cw = '{MUL_NONE, OP_P2_SUB,  1'b0, COND_NEXT, PC_IDLE};
      PC_R2:      cw = '{MUL_NONE, OP_R2,      1'b1, COND_LAST, PC_R2};
      default:    cw = '{MUL_NONE, OP_NOP,     1'b0, COND_JUMP, PC_IDLE};
    endcase
    return cw;
  endfunction

endpackage

>>> sv/midpoint_ellipse_rasterizer_core.sv
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer core
// Walks one quadrant of an ellipse outline and returns four mirrored
// coordinates per emitted point, the last one of each request flagged.
// ----------------------------------------------------------------------------
// Each request (centre, radii) is run by a 14-step microcode program driving
// one registered 12x12 multiplier and an add/compare datapath. After the
// request is taken, three multiplier steps form a2, b2 and a2*b, and the
// init step then sends the first point. Region 1 alternates a test step and
// a point step, the region 2 start-up sets up the decision variable on the
// shared multiplier, and region 2 sends a point at every step. A zero
// vertical radius gives a single point. The result register lets the next
// request be taken while the last point still waits, and a point step
// holds while the previous point is still stalled.
`include "midpoint_ellipse_rasterizer_core_defines.svh"

module midpoint_ellipse_rasterizer_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [mer_pkg::COORD_IN_W-1:0]     center_x,
  input  logic [mer_pkg::COORD_IN_W-1:0]     center_y,
  input  logic [mer_pkg::RAD_W-1:0]          radius_x,
  input  logic [mer_pkg::RAD_W-1:0]          radius_y,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [mer_pkg::COORD_W-1:0] right_x,
  output logic signed [mer_pkg::COORD_W-1:0] left_x,
  output logic signed [mer_pkg::COORD_W-1:0] lower_y,
  output logic signed [mer_pkg::COORD_W-1:0] upper_y,
  output logic                               last_point
);
  import mer_pkg::*;

  function automatic logic signed [P_W-1:0] ext_sq(input logic [SQ_W-1:0] v);
    return signed'({{(P_W-SQ_W){1'b0}}, v});
  endfunction

  function automatic logic signed [P_W-1:0] ext_pp(input logic [PP_W-1:0] v);
    return signed'({{(P_W-PP_W){1'b0}}, v});
  endfunction

  function automatic logic signed [P_W-1:0] ext_prod(input logic [PROD_W-1:0] v);
    return signed'({{(P_W-PROD_W){1'b0}}, v});
  endfunction

  // Sequencer
  logic [PC_W-1:0] pc, pc_next;
  ctrl_word_t      cw;
  logic            hold;

  // Datapath registers
  logic [COORD_IN_W-1:0] cx, cy;
  logic [RAD_W-1:0]      a, b;
  logic [SQ_W-1:0]       a2, b2, v;
  logic [MUL_W-1:0]      u;
  logic [X_W-1:0]        x;
  logic [RAD_W-1:0]      y;
  logic [PP_W-1:0]       px, py;
  logic signed [P_W-1:0] p;
  logic [PROD_W-1:0]     prod;
  logic [N_W-1:0]        n;

  // Multiplier operands
  logic [MUL_W-1:0] mul_a, mul_b;
  logic [RAD_W-1:0] ym;

  // Step values
  logic [PP_W-1:0]       tb2, ta2, px1, py_dec;
  logic [X_W-1:0]        x1;
  logic signed [P_W-1:0] base1, base2;
  logic [RAD_W-1:0]      y_r1, y_r2;
  logic [PP_W-1:0]       py_r1, px_r2;
  logic [X_W-1:0]        x_r2;
  logic signed [P_W-1:0] p_r1, p_r2;
  logic [X_W-1:0]        pt_x;
  logic [RAD_W-1:0]      pt_y;
  logic                  last, cap;
  logic                  out_free, fire;

  assign cw       = ucode(pc);
  assign out_free = !out_valid || !out_stall;
  assign hold     = cw.emit && !out_free;
  assign fire     = cw.emit && !hold;
  assign in_stall = (pc != PC_IDLE);

  always_comb begin
    ym = (y == '0) ? RAD_W'(1) : y - 1'b1;
    unique case (cw.mul)
      MUL_AA:   begin mul_a = MUL_W'(a);  mul_b = MUL_W'(a); end
      MUL_BB:   begin mul_a = MUL_W'(b);  mul_b = MUL_W'(b); end
      MUL_A2B:  begin mul_a = MUL_W'(a2); mul_b = MUL_W'(b); end
      MUL_XX1:  begin mul_a = MUL_W'(x);  mul_b = MUL_W'(x) + 1'b1; end
      MUL_YY:   begin mul_a = MUL_W'(ym); mul_b = MUL_W'(ym); end
      MUL_B2U:  begin mul_a = MUL_W'(b2); mul_b = u; end
      MUL_A2V:  begin mul_a = MUL_W'(a2); mul_b = MUL_W'(v); end
      MUL_A2B2: begin mul_a = MUL_W'(a2); mul_b = MUL_W'(b2); end
      default:  begin mul_a = '0;         mul_b = '0; end
    endcase
  end

  always_comb begin
    tb2    = {{(PP_W-SQ_W-1){1'b0}}, b2, 1'b0};
    ta2    = {{(PP_W-SQ_W-1){1'b0}}, a2, 1'b0};
    x1     = x + 1'b1;
    px1    = px + tb2;
    py_dec = py - ta2;

    // Region 1: step x, and y too when the midpoint lies outside
    base1 = p + ext_sq(b2) + ext_pp(px1);
    if (p < 0) begin
      y_r1  = y;
      py_r1 = py;
      p_r1  = base1;
    end else begin
      y_r1  = y - 1'b1;
      py_r1 = py_dec;
      p_r1  = base1 - ext_pp(py_dec);
    end

    // Region 2: step y, and x too when the midpoint lies inside
    y_r2  = y - 1'b1;
    base2 = p + ext_sq(a2) - ext_pp(py_dec);
    if (p > 0) begin
      x_r2  = x;
      px_r2 = px;
      p_r2  = base2;
    end else begin
      x_r2  = x1;
      px_r2 = px1;
      p_r2  = base2 + ext_pp(px1);
    end

    cap = ((n + 1'b1) == N_W'(MAX_OUT));
    unique case (cw.op)
      OP_INIT: begin
        // zero vertical radius gives only the first point, at the centre
        pt_x = x;
        pt_y = y;
        last = (y == '0);
      end
      OP_R1: begin
        pt_x = x1;
        pt_y = y_r1;
        last = cap || ((y_r1 == '0) && (px1 >= py_r1));
      end
      OP_R2: begin
        pt_x = x_r2;
        pt_y = y_r2;
        last = cap || (y_r2 == '0);
      end
      default: begin
        pt_x = x;
        pt_y = y;
        last = 1'b0;
      end
    endcase
  end

  always_comb begin
    unique case (cw.cond)
      COND_NEXT: pc_next = pc + 1'b1;
      COND_IN:   pc_next = in_valid ? pc + 1'b1 : pc;
      COND_GE:   pc_next = (px >= py) ? cw.target : pc + 1'b1;
      COND_LAST: pc_next = last ? PC_IDLE : cw.target;
      default:   pc_next = cw.target;
    endcase
    if (hold) begin
      pc_next = pc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= PC_IDLE;
      out_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      prod <= {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};
      unique case (cw.op)
        OP_LOAD: begin
          if (in_valid) begin
            cx <= center_x;
            cy <= center_y;
            a  <= radius_x;
            b  <= radius_y;
            x  <= '0;
            y  <= radius_y;
            px <= '0;
            n  <= '0;
          end
        end
        OP_SET_A2: a2 <= prod[SQ_W-1:0];
        OP_SET_B2: b2 <= prod[SQ_W-1:0];
        OP_INIT: begin
          p  <= ext_sq(b2) - ext_prod(prod) + ext_sq({2'b00, a2[SQ_W-1:2]});
          py <= {prod[PP_W-2:0], 1'b0};
        end
        OP_R1: begin
          x  <= x1;
          px <= px1;
          y  <= y_r1;
          py <= py_r1;
          p  <= p_r1;
        end
        OP_SET_U:   u <= prod[MUL_W-1:0];
        OP_SET_V:   v <= prod[SQ_W-1:0];
        OP_P2_BASE: p <= ext_prod(prod) + ext_sq({2'b00, b2[SQ_W-1:2]});
        OP_P2_ADD:  p <= p + ext_prod(prod);
        OP_P2_SUB:  p <= p - ext_prod(prod);
        OP_R2: begin
          x  <= x_r2;
          px <= px_r2;
          y  <= y_r2;
          py <= py_dec;
          p  <= p_r2;
        end
        default: ;
      endcase
    end
    if (fire) begin
      n          <= n + 1'b1;
      right_x    <= signed'({2'b00, cx} + {{(COORD_W-X_W){1'b0}}, pt_x});
      left_x     <= signed'({2'b00, cx} - {{(COORD_W-X_W){1'b0}}, pt_x});
      lower_y    <= signed'({2'b00, cy} + {{(COORD_W-RAD_W){1'b0}}, pt_y});
      upper_y    <= signed'({2'b00, cy} - {{(COORD_W-RAD_W){1'b0}}, pt_y});
      last_point <= last;
    end
  end

  `MER_ASSERT_NEXT(a_start, in_valid && !in_stall, pc == PC_MUL_AA, "request taken but program did not start")
  `MER_ASSERT_IMPL(a_r2_y, pc == PC_R2, y != '0, "region 2 step entered with zero y")
  `MER_ASSERT_NEXT(a_last_idle, fire && last, pc == PC_IDLE, "last point sent but sequencer not idle")
  `MER_ASSERT_NEXT(a_hold, hold, $stable(pc) && out_valid, "point step advanced while output stalled")

endmodule
